[hw/rtl/bq_pkg.sv]
package bq_pkg;

  localparam int DATA_W     = 32;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int FRAC_SHIFT = 24;
  // room for the sum of five full products
  localparam int ACC_W      = PROD_W + 3;
  localparam int EX_W       = ACC_W - FRAC_SHIFT;
  localparam int MAX_TAPS   = 3;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [EX_W-1:0]   ex_t;

  localparam logic [CFG_IDX_W-1:0] CFG_B0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_EN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_HIGH = 3'd7;

  // round half up: half an output LSB
  localparam acc_t HALF_LSB = acc_t'(1) << (FRAC_SHIFT - 1);

  typedef struct packed {
    coef_t   a1;
    coef_t   a2;
    logic    sat_en;
    sample_t lim_low;
    sample_t lim_high;
  } loop_cfg_t;

endpackage

[hw/rtl/bq_if.sv]
interface bq_in_if;
  import bq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bq_out_if;
  import bq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

[hw/rtl/bq_tap.sv]
module bq_tap (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  bq_pkg::coef_t   coef,
  input  bq_pkg::sample_t sample,
  output bq_pkg::sample_t hist,
  output bq_pkg::prod_t   prod
);
  import bq_pkg::*;

  // hold one history sample, hand it to the next tap on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (advance) begin
      hist <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= prod_t'(coef) * prod_t'(sample);
    end
  end

endmodule

[hw/rtl/bq_loop.sv]
module bq_loop #(
  parameter int FILTER_ORDER = 2,
  parameter int SAT_W        = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  bq_pkg::acc_t      ff_sum,
  input  bq_pkg::loop_cfg_t cfg,
  output bq_pkg::sample_t   y,
  output logic              sat
);
  import bq_pkg::*;

  localparam ex_t SMAX = ex_t'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam ex_t SMIN = ~SMAX;

  sample_t y2;
  prod_t   pa1;
  prod_t   pa2;
  acc_t    acc;
  ex_t     ex;
  ex_t     lim_low_x;
  ex_t     lim_high_x;
  ex_t     clamped;
  ex_t     y_next;
  logic    sat_next;

  assign pa1        = prod_t'(cfg.a1) * prod_t'(y);
  assign acc        = ff_sum - acc_t'(pa1) - acc_t'(pa2);
  assign ex         = acc[ACC_W-1:FRAC_SHIFT];
  assign lim_low_x  = ex_t'(cfg.lim_low);
  assign lim_high_x = ex_t'(cfg.lim_high);

  always_comb begin
    clamped = ex;
    if (cfg.sat_en) begin
      if (ex > lim_high_x) begin
        clamped = lim_high_x;
      end else if (ex < lim_low_x) begin
        clamped = lim_low_x;
      end
    end
    y_next = clamped;
    if (clamped > SMAX) begin
      y_next = SMAX;
    end else if (clamped < SMIN) begin
      y_next = SMIN;
    end
    sat_next = (y_next != ex);
  end

  // y doubles as the output register and the newest output history
  always_ff @(posedge clk) begin
    if (rst) begin
      y   <= '0;
      y2  <= '0;
      sat <= 1'b0;
    end else if (advance) begin
      y   <= sample_t'(y_next);
      y2  <= y;
      sat <= sat_next;
    end
  end

  // a2 term is registered ahead of time from what will be the older output
  if (FILTER_ORDER >= 2) begin : g_a2
    always_ff @(posedge clk) begin
      if (rst) begin
        pa2 <= '0;
      end else begin
        pa2 <= prod_t'(cfg.a2) * prod_t'(advance ? y : y2);
      end
    end
  end else begin : g_no_a2
    assign pa2 = '0;
  end

endmodule

[hw/rtl/biquad_iir_filter_saturating_core.sv]
// Direct-form-I biquad with optional output clamp. One sample is taken per clock cycle,
// sustained while results are accepted. The tap stage registers the b products in the row
// of feed-forward taps, the sum stage registers their sum with the rounding half, and the
// recursion stage writes the output register, where the a1 product of the previous output,
// the final sum, the rounding cut and the clamp all close combinationally so that
// consecutive samples can follow each other.
// Coefficients are Q8.24 with prescaler and leading denominator folded in; write them
// only while no sample is in flight. Reset clears the history.
module biquad_iir_filter_saturating_core #(
  parameter int FILTER_ORDER = 2,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  bq_in_if.sink                          samples,
  bq_out_if.source                       results,
  input  logic                           cfg_write,
  input  logic [bq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bq_pkg::DATA_W-1:0]      cfg_data
);
  import bq_pkg::*;

  localparam int SAT_W = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
  localparam int NTAP  = FILTER_ORDER + 1;

  coef_t     coef_b [MAX_TAPS];
  coef_t     coef_a1;
  coef_t     coef_a2;
  logic      sat_en;
  sample_t   lim_low;
  sample_t   lim_high;
  loop_cfg_t loop_cfg;

  logic signed [SAT_W-1:0] x_low;
  sample_t   x;
  sample_t   tap_in   [NTAP];
  sample_t   tap_hist [NTAP];
  prod_t     tap_prod [NTAP];

  logic      s1_valid;
  logic      s2_valid;
  logic      out_valid;
  logic      adv1;
  logic      adv2;
  logic      adv3;
  acc_t      ff_sum;
  acc_t      ff_sum_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef_b[k] <= '0;
      end
      coef_a1  <= '0;
      coef_a2  <= '0;
      sat_en   <= 1'b0;
      lim_low  <= '0;
      lim_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_B0:       coef_b[0] <= cfg_data;
        CFG_B1:       coef_b[1] <= cfg_data;
        CFG_B2:       coef_b[2] <= cfg_data;
        CFG_A1:       coef_a1   <= cfg_data;
        CFG_A2:       coef_a2   <= cfg_data;
        CFG_SAT_EN:   sat_en    <= cfg_data[0];
        CFG_LIM_LOW:  lim_low   <= cfg_data;
        CFG_LIM_HIGH: lim_high  <= cfg_data;
      endcase
    end
  end

  assign loop_cfg = '{a1: coef_a1, a2: coef_a2, sat_en: sat_en,
                      lim_low: lim_low, lim_high: lim_high};

  // pipeline control
  assign adv3          = s2_valid && (!out_valid || results.ready);
  assign adv2          = s1_valid && (!s2_valid || adv3);
  assign samples.ready = !s1_valid || adv2;
  assign adv1          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= 1'b1;
      end else if (adv2) begin
        s1_valid <= 1'b0;
      end
      if (adv2) begin
        s2_valid <= 1'b1;
      end else if (adv3) begin
        s2_valid <= 1'b0;
      end
      if (adv3) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sign-extend from the sample width, ignore the bits above
  assign x_low = samples.sample_in[SAT_W-1:0];
  assign x     = sample_t'(x_low);

  for (genvar k = 0; k < NTAP; k++) begin : g_tap
    if (k == 0) begin : g_first
      assign tap_in[k] = x;
    end else begin : g_next
      assign tap_in[k] = tap_hist[k-1];
    end
    bq_tap u_tap (
      .clk     (clk),
      .rst     (rst),
      .advance (adv1),
      .coef    (coef_b[k]),
      .sample  (tap_in[k]),
      .hist    (tap_hist[k]),
      .prod    (tap_prod[k])
    );
  end

  always_comb begin
    ff_sum_next = HALF_LSB;
    for (int k = 0; k < NTAP; k++) begin
      ff_sum_next = ff_sum_next + acc_t'(tap_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      ff_sum <= ff_sum_next;
    end
  end

  bq_loop #(
    .FILTER_ORDER (FILTER_ORDER),
    .SAT_W        (SAT_W)
  ) u_loop (
    .clk     (clk),
    .rst     (rst),
    .advance (adv3),
    .ff_sum  (ff_sum),
    .cfg     (loop_cfg),
    .y       (results.sample_out),
    .sat     (results.saturated)
  );

  assign results.valid = out_valid;

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    adv3 |=> results.valid)
    else $error("result moved into the output register but valid is low");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv2 |=> s1_valid)
    else $error("item lost from the tap stage");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !adv3 |=> s2_valid)
    else $error("item lost from the sum stage");

  a_within_limits: assert property (@(posedge clk) disable iff (rst)
    results.valid && sat_en && (lim_low <= lim_high) && (SAT_W == DATA_W)
      |-> (results.sample_out >= lim_low) && (results.sample_out <= lim_high))
    else $error("clamped output outside the configured limits");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bq_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RESET_CYCLES = 7;

  localparam coef_t   Q24_ONE    = 32'sh0100_0000;
  localparam coef_t   Q24_HALF   = 32'sh0080_0000;
  localparam coef_t   COEF_MAX   = 32'sh7FFF_FFFF;
  localparam coef_t   COEF_MIN   = 32'sh8000_0000;
  localparam sample_t Q16_ONE    = 32'sh0001_0000;
  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;
  localparam ex_t     EX_MAX     = ex_t'(SAMPLE_MAX);
  localparam ex_t     EX_MIN     = ex_t'(SAMPLE_MIN);

  typedef struct packed {
    sample_t sample_out;
    logic    saturated;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  bq_in_if  in_if ();
  bq_out_if out_if ();

  // filter settings and history as the block should hold them
  coef_t   filt_b0, filt_b1, filt_b2, filt_a1, filt_a2;
  logic    filt_sat_en;
  sample_t filt_lim_low, filt_lim_high;
  sample_t x_prev1, x_prev2, y_prev1, y_prev2;

  filt_result_t expected_results [$];
  int errors        = 0;
  int stall_cycles  = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 79;

  biquad_iir_filter_saturating_core #(
    .FILTER_ORDER (2),
    .SAMPLE_WIDTH (32)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (in_if),
    .results   (out_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Exact sum of the five products, round half up, clamp, then range saturation.
  function automatic filt_result_t filter_step(input sample_t x);
    acc_t         acc;
    ex_t          ex;
    ex_t          yv;
    filt_result_t r;
    acc = filt_b0 * x + filt_b1 * x_prev1 + filt_b2 * x_prev2
          - filt_a1 * y_prev1 - filt_a2 * y_prev2 + HALF_LSB;
    ex = acc[ACC_W-1:FRAC_SHIFT];
    yv = ex;
    if (filt_sat_en) begin
      if (yv > filt_lim_high) yv = ex_t'(filt_lim_high);
      else if (yv < filt_lim_low) yv = ex_t'(filt_lim_low);
    end
    if (yv > EX_MAX) yv = EX_MAX;
    else if (yv < EX_MIN) yv = EX_MIN;
    r.sample_out = yv[DATA_W-1:0];
    r.saturated  = (yv != ex);
    x_prev2 = x_prev1;
    x_prev1 = x;
    y_prev2 = y_prev1;
    y_prev1 = yv[DATA_W-1:0];
    return r;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return sample_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      8: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // kind 0: any word, kind 2: extremes, otherwise within about +-1.5
  function automatic coef_t pick_coef(input int kind);
    case (kind)
      0: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return Q24_ONE;
          default: return -Q24_ONE;
        endcase
      end
      default: return coef_t'($urandom_range(0, 32'h0300_0000)) - 32'sh0180_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure_filter(input coef_t b0, b1, b2, a1, a2, input logic sat_en,
                                  input sample_t lim_low, lim_high);
    logic [DATA_W-1:0] en_word;
    en_word    = $urandom;
    en_word[0] = sat_en;
    write_reg(CFG_B0, b0);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_SAT_EN, en_word);
    write_reg(CFG_LIM_LOW, lim_low);
    write_reg(CFG_LIM_HIGH, lim_high);
    cfg_write <= 1'b0;
    filt_b0       = b0;
    filt_b1       = b1;
    filt_b2       = b2;
    filt_a1       = a1;
    filt_a2       = a2;
    filt_sat_en   = sat_en;
    filt_lim_low  = lim_low;
    filt_lim_high = lim_high;
  endtask

  task automatic send_sample(input sample_t x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(filter_step(x));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all coefficients zero after reset: every output is zero
  task automatic test_reset_state();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-32'sd1);
    wait_drained();
  endtask

  // half an LSB rounds up, so -0.5 goes to zero
  task automatic test_rounding();
    configure_filter(Q24_HALF, '0, '0, '0, '0, 1'b0, '0, '0);
    send_sample(32'sd1);
    send_sample(-32'sd1);
    send_sample(32'sd3);
    send_sample(-32'sd3);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    wait_drained();
  endtask

  task automatic test_range_saturation();
    configure_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b0, '0, '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    wait_drained();
  endtask

  // integrator: y = x + y1, clamped to +-5.0; the clamped value feeds back
  task automatic test_clamp_limits();
    configure_filter(Q24_ONE, '0, '0, -Q24_ONE, '0, 1'b1, -5 * Q16_ONE, 5 * Q16_ONE);
    repeat (4) send_sample(2 * Q16_ONE);
    repeat (2) send_sample(-8 * Q16_ONE);
    wait_drained();
  endtask

  // low limit above high limit: the high test wins
  task automatic test_crossed_limits();
    configure_filter(Q24_ONE, '0, '0, '0, '0, 1'b1, 10 * Q16_ONE, -10 * Q16_ONE);
    send_sample('0);
    send_sample(20 * Q16_ONE);
    send_sample(-20 * Q16_ONE);
    wait_drained();
  endtask

  task automatic test_random_stream(input int n_sets, input int per_set);
    int      kind;
    sample_t lim_a, lim_b, swap;
    for (int s = 0; s < n_sets; s++) begin
      kind  = $urandom_range(0, 3);
      lim_a = pick_sample();
      lim_b = pick_sample();
      // mostly ordered limits, now and then crossed
      if ($urandom_range(0, 4) != 0 && lim_a > lim_b) begin
        swap  = lim_a;
        lim_a = lim_b;
        lim_b = swap;
      end
      configure_filter(pick_coef(kind), pick_coef(kind), pick_coef(kind), pick_coef(kind),
                       pick_coef(kind), $urandom_range(0, 1), lim_a, lim_b);
      repeat (per_set) send_sample(pick_sample());
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    filt_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: sample_out %h saturated %b",
                 $time, out_if.sample_out, out_if.saturated);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.sample_out !== want.sample_out) begin
          $display("%0t: sample_out mismatch: expected %h actual %h",
                   $time, want.sample_out, out_if.sample_out);
          errors++;
        end
        if (out_if.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch: expected %b actual %b",
                   $time, want.saturated, out_if.saturated);
          errors++;
        end
      end
    end
  end

  // count cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    filt_b0         = '0;
    filt_b1         = '0;
    filt_b2         = '0;
    filt_a1         = '0;
    filt_a2         = '0;
    filt_sat_en     = 1'b0;
    filt_lim_low    = '0;
    filt_lim_high   = '0;
    x_prev1         = '0;
    x_prev2         = '0;
    y_prev1         = '0;
    y_prev2         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_rounding();
    test_range_saturation();
    test_clamp_limits();
    test_crossed_limits();
    test_random_stream(4, 84);

    send_idle_pct = 79;
    recv_idle_pct = 8;
    test_random_stream(4, 84);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(4, 84);

    wait_drained();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
